FILE: rtl/dnsqp_pkg.sv
`default_nettype none

package dnsqp_pkg;

    // Fixed header length of a message, first byte included (1 to 16)
    localparam int unsigned HEADER_BYTES = 12;
    // Most labels a question name may hold (1 to 64)
    localparam int unsigned MAX_LABELS   = 64;
    // Longest legal label
    localparam logic [7:0]  LABEL_LIMIT  = 8'd63;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_LEN    = 3'd2,
        PH_LABEL  = 3'd3,
        PH_TAIL   = 3'd4,
        PH_DRAIN  = 3'd5
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

`default_nettype wire

FILE: rtl/dns_question_name_parser.sv
// Registers: an accepted byte passes the input register, then the result
//   register; a full result slot holds the byte in the input register.
// Throughput: one byte per cycle while the result slot is free; the next parse
//   state is computed combinationally from the input register.
// Reset: rst_n is asynchronous and active low; it clears the parse state to
//   idle, empties both registers, and bytes are ignored until a first byte.
`default_nettype none

module dns_question_name_parser
#(
    parameter int unsigned HEADER_BYTES = dnsqp_pkg::HEADER_BYTES,
    parameter int unsigned MAX_LABELS   = dnsqp_pkg::MAX_LABELS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        first_byte,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       kind,
    output logic [5:0]       label_index,
    output logic [5:0]       char_position,
    output logic [7:0]       label_char,
    output logic [15:0]      query_type,
    output logic [15:0]      query_class,
    output logic [6:0]       label_count
);

    import dnsqp_pkg::*;

    localparam logic [3:0] HDR_START  = 4'(HEADER_BYTES - 1);
    localparam logic [6:0] LABEL_MAX7 = 7'(MAX_LABELS);

    // Input register
    logic       stage_valid_reg;
    logic       stage_first_reg;
    logic [7:0] stage_data_reg;

    // Parse state
    phase_t      phase_reg,       phase_next;
    logic [3:0]  header_left_reg, header_left_next;
    logic [5:0]  label_left_reg,  label_left_next;
    logic [5:0]  char_pos_reg,    char_pos_next;
    logic [6:0]  labels_seen_reg, labels_seen_next;
    logic [1:0]  tail_count_reg,  tail_count_next;
    logic [23:0] tail_bytes_reg,  tail_bytes_next;

    // Result register
    logic        result_valid_reg;
    kind_t       kind_reg;
    logic [5:0]  label_index_reg;
    logic [5:0]  char_position_reg;
    logic [7:0]  label_char_reg;
    logic [15:0] query_type_reg;
    logic [15:0] query_class_reg;
    logic [6:0]  label_count_reg;

    // Result of the staged byte
    logic        res_present;
    kind_t       res_kind;
    logic [5:0]  res_index;
    logic [5:0]  res_pos;
    logic [7:0]  res_char;
    logic [15:0] res_qtype;
    logic [15:0] res_qclass;
    logic [6:0]  res_count;

    logic out_free;
    logic fire;
    logic len_bad;

    // Handshake: the staged byte moves on once the result slot is free
    assign out_free   = !result_valid_reg || result_ready;
    assign fire       = stage_valid_reg && out_free;
    assign item_ready = !stage_valid_reg || fire;

    assign len_bad = (stage_data_reg > LABEL_LIMIT) || (labels_seen_reg >= LABEL_MAX7);

    // Next parse state
    always_comb
    begin
        phase_next       = phase_reg;
        header_left_next = header_left_reg;
        label_left_next  = label_left_reg;
        char_pos_next    = char_pos_reg;
        labels_seen_next = labels_seen_reg;
        tail_count_next  = tail_count_reg;
        tail_bytes_next  = tail_bytes_reg;
        if (stage_first_reg)
        begin
            labels_seen_next = '0;
            label_left_next  = '0;
            char_pos_next    = '0;
            tail_count_next  = '0;
            tail_bytes_next  = '0;
            header_left_next = HDR_START;
            phase_next       = (HDR_START == 4'd0) ? PH_LEN : PH_HEADER;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    header_left_next = header_left_reg - 4'd1;
                    if (header_left_reg == 4'd1)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (stage_data_reg == 8'd0)
                    begin
                        phase_next      = PH_TAIL;
                        tail_count_next = '0;
                        tail_bytes_next = '0;
                    end
                    else if (len_bad)
                        phase_next = PH_DRAIN;
                    else
                    begin
                        label_left_next = stage_data_reg[5:0];
                        char_pos_next   = '0;
                        phase_next      = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    char_pos_next   = char_pos_reg + 6'd1;
                    label_left_next = label_left_reg - 6'd1;
                    if (label_left_reg == 6'd1)
                    begin
                        labels_seen_next = labels_seen_reg + 7'd1;
                        phase_next       = PH_LEN;
                    end
                end
                PH_TAIL:
                begin
                    if (tail_count_reg != 2'd3)
                    begin
                        tail_bytes_next = {tail_bytes_reg[15:0], stage_data_reg};
                        tail_count_next = tail_count_reg + 2'd1;
                    end
                    else
                        phase_next = PH_DRAIN;
                end
                PH_IDLE, PH_DRAIN:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of the staged byte
    always_comb
    begin
        res_present = 1'b0;
        res_kind    = KIND_CHAR;
        res_index   = '0;
        res_pos     = '0;
        res_char    = '0;
        res_qtype   = '0;
        res_qclass  = '0;
        res_count   = '0;
        if (!stage_first_reg)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (stage_data_reg != 8'd0 && len_bad)
                    begin
                        res_present = 1'b1;
                        res_kind    = KIND_BAD;
                        res_count   = labels_seen_reg;
                    end
                end
                PH_LABEL:
                begin
                    res_present = 1'b1;
                    res_kind    = KIND_CHAR;
                    res_index   = labels_seen_reg[5:0];
                    res_pos     = char_pos_reg;
                    res_char    = stage_data_reg;
                end
                PH_TAIL:
                begin
                    if (tail_count_reg == 2'd3)
                    begin
                        res_present = 1'b1;
                        res_kind    = KIND_DONE;
                        res_qtype   = tail_bytes_reg[23:8];
                        res_qclass  = {tail_bytes_reg[7:0], stage_data_reg};
                        res_count   = labels_seen_reg;
                    end
                end
                PH_IDLE, PH_HEADER, PH_DRAIN:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_IDLE;
            header_left_reg  <= '0;
            label_left_reg   <= '0;
            char_pos_reg     <= '0;
            labels_seen_reg  <= '0;
            tail_count_reg   <= '0;
            tail_bytes_reg   <= '0;
        end
        else
        begin
            if (item_ready)
                stage_valid_reg <= item_valid;
            if (fire)
                result_valid_reg <= res_present;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (fire)
            begin
                phase_reg       <= phase_next;
                header_left_reg <= header_left_next;
                label_left_reg  <= label_left_next;
                char_pos_reg    <= char_pos_next;
                labels_seen_reg <= labels_seen_next;
                tail_count_reg  <= tail_count_next;
                tail_bytes_reg  <= tail_bytes_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_first_reg <= first_byte;
            stage_data_reg  <= data_byte;
        end
        if (fire && res_present)
        begin
            kind_reg          <= res_kind;
            label_index_reg   <= res_index;
            char_position_reg <= res_pos;
            label_char_reg    <= res_char;
            query_type_reg    <= res_qtype;
            query_class_reg   <= res_qclass;
            label_count_reg   <= res_count;
        end
    end

    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign label_index   = label_index_reg;
    assign char_position = char_position_reg;
    assign label_char    = label_char_reg;
    assign query_type    = query_type_reg;
    assign query_class   = query_class_reg;
    assign label_count   = label_count_reg;

    // A character result comes only from inside a label
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_present && res_kind == KIND_CHAR |-> phase_reg == PH_LABEL)
        else $error("character result outside a label");

    // Inside a label there is always at least one byte left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LABEL |-> label_left_reg != 6'd0)
        else $error("label phase with no bytes left");

    // Done or malformed sends the parser to drain
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_present && res_kind != KIND_CHAR |=> phase_reg == PH_DRAIN)
        else $error("parser not draining after a final result");

    // Label count never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        labels_seen_reg <= LABEL_MAX7)
        else $error("label count beyond limit");

    // A new result is loaded only when the slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!result_valid_reg || result_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import dnsqp_pkg::*;

    // One result of the parser, as the predictor expects it
    typedef struct {
        kind_t        kind;
        logic [5:0]   label_index;
        logic [5:0]   char_position;
        logic [7:0]   label_char;
        logic [15:0]  query_type;
        logic [15:0]  query_class;
        logic [6:0]   label_count;
    } qname_result_t;

    // Predicts the parser from accepted requests and checks its results
    class qname_scoreboard;
        phase_t          phase;
        logic [3:0]      header_left;
        logic [5:0]      label_left;
        logic [5:0]      char_pos;
        logic [6:0]      labels_seen;
        logic [1:0]      tail_count;
        logic [23:0]     tail_bytes;
        qname_result_t   pending_results[$];
        int              errors;

        function new();
            phase       = PH_IDLE;
            header_left = '0;
            label_left  = '0;
            char_pos    = '0;
            labels_seen = '0;
            tail_count  = '0;
            tail_bytes  = '0;
            errors      = 0;
        endfunction

        // Advance the parse by one byte and queue any result it causes
        function void take_byte(logic first, logic [7:0] b);
            qname_result_t r;
            bit            hit;
            hit             = 1'b0;
            r.kind          = KIND_CHAR;
            r.label_index   = '0;
            r.char_position = '0;
            r.label_char    = '0;
            r.query_type    = '0;
            r.query_class   = '0;
            r.label_count   = '0;
            if (first)
            begin
                labels_seen = '0;
                label_left  = '0;
                char_pos    = '0;
                tail_count  = '0;
                tail_bytes  = '0;
                header_left = 4'(HEADER_BYTES - 1);
                phase       = (header_left == 4'd0) ? PH_LEN : PH_HEADER;
            end
            else
            begin
                case (phase)
                    PH_HEADER:
                    begin
                        header_left = header_left - 4'd1;
                        if (header_left == 4'd0)
                            phase = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (b == 8'd0)
                        begin
                            phase      = PH_TAIL;
                            tail_count = '0;
                            tail_bytes = '0;
                        end
                        else if (b > LABEL_LIMIT || labels_seen >= MAX_LABELS)
                        begin
                            phase         = PH_DRAIN;
                            r.kind        = KIND_BAD;
                            r.label_count = labels_seen;
                            hit           = 1'b1;
                        end
                        else
                        begin
                            label_left = b[5:0];
                            char_pos   = '0;
                            phase      = PH_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        r.kind          = KIND_CHAR;
                        r.label_index   = labels_seen[5:0];
                        r.char_position = char_pos;
                        r.label_char    = b;
                        hit             = 1'b1;
                        char_pos        = char_pos + 6'd1;
                        label_left      = label_left - 6'd1;
                        if (label_left == 6'd0)
                        begin
                            labels_seen = labels_seen + 7'd1;
                            phase       = PH_LEN;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (tail_count < 2'd3)
                        begin
                            tail_bytes = {tail_bytes[15:0], b};
                            tail_count = tail_count + 2'd1;
                        end
                        else
                        begin
                            phase         = PH_DRAIN;
                            r.kind        = KIND_DONE;
                            r.query_type  = tail_bytes[23:8];
                            r.query_class = {tail_bytes[7:0], b};
                            r.label_count = labels_seen;
                            hit           = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (hit)
                pending_results.push_back(r);
        endfunction

        // Compare one result from the parser with the oldest expectation
        function void match_result(logic [1:0] k, logic [5:0] idx, logic [5:0] pos,
                                   logic [7:0] ch, logic [15:0] qt, logic [15:0] qc,
                                   logic [6:0] cnt);
            qname_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0h, label_count %0h", k, cnt);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0h, got %0h", e.kind, k);
                errors++;
            end
            if (idx !== e.label_index)
            begin
                $error("label_index: expected %0h, got %0h", e.label_index, idx);
                errors++;
            end
            if (pos !== e.char_position)
            begin
                $error("char_position: expected %0h, got %0h", e.char_position, pos);
                errors++;
            end
            if (ch !== e.label_char)
            begin
                $error("label_char: expected %0h, got %0h", e.label_char, ch);
                errors++;
            end
            if (qt !== e.query_type)
            begin
                $error("query_type: expected %0h, got %0h", e.query_type, qt);
                errors++;
            end
            if (qc !== e.query_class)
            begin
                $error("query_class: expected %0h, got %0h", e.query_class, qc);
                errors++;
            end
            if (cnt !== e.label_count)
            begin
                $error("label_count: expected %0h, got %0h", e.label_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        first_byte   = 1'b0;
    logic [7:0]  data_byte    = 8'd0;
    logic        result_ready = 1'b0;
    logic        item_ready;
    logic        result_valid;
    logic [1:0]  kind;
    logic [5:0]  label_index;
    logic [5:0]  char_position;
    logic [7:0]  label_char;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [6:0]  label_count;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    qname_scoreboard sb = new();

    dns_question_name_parser uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .first_byte    (first_byte),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .label_index   (label_index),
        .char_position (char_position),
        .label_char    (label_char),
        .query_type    (query_type),
        .query_class   (query_class),
        .label_count   (label_count)
    );

    always #6 clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Both handshakes observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.match_result(kind, label_index, char_position, label_char,
                                query_type, query_class, label_count);
            if (item_valid && item_ready)
                sb.take_byte(first_byte, data_byte);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic first, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        first_byte <= first;
        data_byte  <= b;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i])
            send_byte(i == 0, msg[i]);
    endtask

    // Fresh message holding only the fixed header with random content
    function automatic void open_message(ref logic [7:0] msg[$]);
        msg = {};
        repeat (HEADER_BYTES)
            msg.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void push_label(ref logic [7:0] msg[$], input int len);
        msg.push_back(8'(len));
        repeat (len)
            msg.push_back(8'($urandom_range(255)));
    endfunction

    // Mostly well-formed questions; some malformed, cut short or overlong
    task automatic random_message(inout int sent);
        logic [7:0] msg[$];
        int         style;
        int         n_labels;
        int         cut;
        style = $urandom_range(99);
        open_message(msg);
        n_labels = (style < 3) ? MAX_LABELS : $urandom_range(0, 4);
        repeat (n_labels)
            push_label(msg, (style < 3) ? 1 :
                            ($urandom_range(19) == 0) ? 63 : $urandom_range(1, 8));
        if (style < 3)
        begin
            // label limit reached: a terminator or one label too many
            msg.push_back(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
            repeat (4)
                msg.push_back(8'($urandom_range(255)));
        end
        else if (style < 80)
        begin
            msg.push_back(8'd0);
            repeat (4)
                msg.push_back(8'($urandom_range(255)));
        end
        else if (style < 90)
        begin
            msg.push_back(8'($urandom_range(64, 255)));
            repeat (3)
                msg.push_back(8'($urandom_range(255)));
        end
        else
        begin
            // cut off; the next start restarts the parse
            msg.push_back(8'd0);
            repeat (4)
                msg.push_back(8'($urandom_range(255)));
            cut = $urandom_range(1, msg.size() - 1);
            msg = msg[0:cut-1];
        end
        repeat ($urandom_range(0, 2))
            msg.push_back(8'($urandom_range(255)));
        sent += msg.size();
        send_message(msg);
    endtask

    initial
    begin
        logic [7:0]  msg[$];
        int unsigned send_idle[4];
        int unsigned recv_stall[4];
        int          sent;

        send_idle  = '{0, 51, 0, 11};
        recv_stall = '{0, 0, 51, 11};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes before any start are ignored
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);

        // two labels, extreme characters and tail, then a byte after done
        open_message(msg);
        msg.push_back(8'd1);
        msg.push_back(8'h00);
        msg.push_back(8'd2);
        msg.push_back(8'hFF);
        msg.push_back(8'h7F);
        msg.push_back(8'd0);
        msg.push_back(8'hFF);
        msg.push_back(8'hFF);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        send_message(msg);

        // empty name
        open_message(msg);
        msg.push_back(8'd0);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        msg.push_back(8'hFF);
        send_message(msg);

        // length just over the limit
        open_message(msg);
        msg.push_back(8'd64);
        send_message(msg);

        // longest label, then the largest length byte
        open_message(msg);
        push_label(msg, 63);
        msg.push_back(8'hFF);
        send_message(msg);

        // restart in the middle of a label
        open_message(msg);
        msg.push_back(8'd3);
        msg.push_back(8'h61);
        send_message(msg);

        // label limit reached, then properly terminated
        open_message(msg);
        repeat (MAX_LABELS)
            push_label(msg, 1);
        msg.push_back(8'd0);
        repeat (4)
            msg.push_back(8'($urandom_range(255)));
        send_message(msg);

        // label limit reached, then one label too many
        open_message(msg);
        repeat (MAX_LABELS)
            push_label(msg, 1);
        msg.push_back(8'd1);
        send_message(msg);

        // random traffic under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = send_idle[p];
            stall_pct = recv_stall[p];
            sent      = 0;
            while (sent < 40)
                random_message(sent);
        end

        item_valid <= 1'b0;
        stall_pct = 0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        // allow a margin for stray results
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
